### design/rtc_calendar_with_weekday_top_assert.svh
// Assertion helpers for the calendar block.
`ifndef RTC_CALENDAR_WITH_WEEKDAY_TOP_ASSERT_SVH
`define RTC_CALENDAR_WITH_WEEKDAY_TOP_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define RTCWD_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// ante holds -> cons holds in the next cycle
`define RTCWD_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/rtcwd_pkg.sv
package rtcwd_pkg;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_START  = 2'd1,
      CMD_SET    = 2'd2
   } rtcwd_cmd_type;

   typedef enum logic [2:0] {
      LEVEL_NONE   = 3'd0,
      LEVEL_SECOND = 3'd1,
      LEVEL_MINUTE = 3'd2,
      LEVEL_HOUR   = 3'd3,
      LEVEL_DAY    = 3'd4,
      LEVEL_MONTH  = 3'd5,
      LEVEL_YEAR   = 3'd6
   } rtcwd_level_type;

   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } rtcwd_date_type;

   localparam logic [31:0] CPS_RESET       = 32'd1000000;
   localparam logic [5:0]  SECS_PER_MIN    = 6'd60;
   localparam logic [5:0]  MINS_PER_HOUR   = 6'd60;
   localparam logic [4:0]  HOURS_PER_DAY   = 5'd24;
   localparam logic [3:0]  MONTH_LIMIT     = 4'd13;
   localparam logic [6:0]  YEAR_LIMIT      = 7'd100;
   localparam logic [6:0]  PREV_YEAR_ZERO  = 7'd4;
   localparam logic [3:0]  MONTH_FEB       = 4'd2;
   localparam logic [2:0]  DAYS_PER_WEEK   = 3'd7;

   localparam rtcwd_date_type DATE_RESET = '{
      year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0
   };

   function automatic logic [4:0] days_in_month(input logic [6:0] year,
                                                input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd2:                      len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      if (month == MONTH_FEB && year[1:0] == 2'b00) begin
         len = 5'd29;
      end
      return len;
   endfunction

   // (13*m - 1) / 5 with m the March-based month number
   function automatic logic [5:0] month_offset(input logic [3:0] month);
      logic [5:0] ofs;
      case (month)
         4'd0:    ofs = 6'd25;
         4'd1:    ofs = 6'd28;
         4'd2:    ofs = 6'd31;
         4'd3:    ofs = 6'd2;
         4'd4:    ofs = 6'd5;
         4'd5:    ofs = 6'd7;
         4'd6:    ofs = 6'd10;
         4'd7:    ofs = 6'd12;
         4'd8:    ofs = 6'd15;
         4'd9:    ofs = 6'd18;
         4'd10:   ofs = 6'd20;
         4'd11:   ofs = 6'd23;
         4'd12:   ofs = 6'd25;
         4'd13:   ofs = 6'd28;
         4'd14:   ofs = 6'd31;
         default: ofs = 6'd33;
      endcase
      return ofs;
   endfunction

   // 8 = 1 mod 7, so octal digits fold
   function automatic logic [2:0] mod7(input logic [7:0] v);
      logic [4:0] s1;
      logic [3:0] s2;
      logic [3:0] r;
      s1 = {2'b00, v[2:0]} + {2'b00, v[5:3]} + {3'b000, v[7:6]};
      s2 = {1'b0, s1[2:0]} + {2'b00, s1[4:3]};
      r  = (s2 >= {1'b0, DAYS_PER_WEEK}) ? s2 - {1'b0, DAYS_PER_WEEK} : s2;
      return r[2:0];
   endfunction

endpackage

### design/rtcwd_timekeeper.sv
module rtcwd_timekeeper
   import rtcwd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [31:0]     csr_write_data,
   input  logic            step_valid,
   input  logic [1:0]      cmd,
   input  logic [31:0]     counter_value,
   input  rtcwd_date_type  load_date,
   output rtcwd_level_type level,
   output rtcwd_date_type  date_next
);

   logic [31:0]    cps_ff;
   logic [31:0]    deadline_ff;
   logic [31:0]    deadline_in;
   rtcwd_date_type date_ff;
   rtcwd_date_type date_in;
   logic [15:0]    diff;
   logic           due;
   logic [5:0]     sec_inc;
   logic [5:0]     min_inc;
   logic [4:0]     hour_inc;
   logic [4:0]     day_inc;
   logic [3:0]     month_inc;
   logic [6:0]     year_inc;
   logic [31:0]    deadline_step;
   logic [31:0]    deadline_start;

   assign diff           = counter_value[31:16] - deadline_ff[31:16];
   assign due            = ~diff[15];
   assign sec_inc        = date_ff.second + 6'd1;
   assign min_inc        = date_ff.minute + 6'd1;
   assign hour_inc       = date_ff.hour + 5'd1;
   assign day_inc        = date_ff.day + 5'd1;
   assign month_inc      = date_ff.month + 4'd1;
   assign year_inc       = date_ff.year + 7'd1;
   assign deadline_step  = deadline_ff + cps_ff;
   assign deadline_start = counter_value + cps_ff;

   always_comb begin
      deadline_in = deadline_ff;
      date_in     = date_ff;
      level       = LEVEL_NONE;
      if (step_valid) begin
         case (cmd)
            CMD_SAMPLE: begin
               if (due) begin
                  deadline_in    = deadline_step;
                  date_in.second = sec_inc;
                  level          = LEVEL_SECOND;
                  if (sec_inc >= SECS_PER_MIN) begin
                     date_in.second = '0;
                     date_in.minute = min_inc;
                     level          = LEVEL_MINUTE;
                     if (min_inc >= MINS_PER_HOUR) begin
                        date_in.minute = '0;
                        date_in.hour   = hour_inc;
                        level          = LEVEL_HOUR;
                        if (hour_inc >= HOURS_PER_DAY) begin
                           date_in.hour = '0;
                           date_in.day  = day_inc;
                           level        = LEVEL_DAY;
                           if (day_inc == '0 ||
                               day_inc > days_in_month(date_ff.year, date_ff.month)) begin
                              date_in.day   = 5'd1;
                              date_in.month = month_inc;
                              level         = LEVEL_MONTH;
                              if (month_inc == '0 || month_inc >= MONTH_LIMIT) begin
                                 date_in.month = 4'd1;
                                 date_in.year  = year_inc;
                                 level         = LEVEL_YEAR;
                                 // century wrap reports a plain second tick
                                 if (year_inc == '0 || year_inc >= YEAR_LIMIT) begin
                                    date_in.year = '0;
                                    level        = LEVEL_SECOND;
                                 end
                              end
                           end
                        end
                     end
                  end
               end
            end
            CMD_START: begin
               deadline_in = deadline_start;
            end
            CMD_SET: begin
               date_in = load_date;
            end
            default: begin
            end
         endcase
      end
   end

   assign date_next = date_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cps_ff      <= CPS_RESET;
         deadline_ff <= '0;
         date_ff     <= DATE_RESET;
      end else begin
         if (csr_write_enable) begin
            cps_ff <= csr_write_data;
         end
         deadline_ff <= deadline_in;
         date_ff     <= date_in;
      end
   end

endmodule

### design/rtcwd_weekday.sv
module rtcwd_weekday
   import rtcwd_pkg::*;
(
   input  rtcwd_date_type date,
   output logic [2:0]     weekday
);

   logic       jan_feb;
   logic [6:0] y;
   logic [7:0] sum;

   assign jan_feb = (date.month <= MONTH_FEB);

   always_comb begin
      if (!jan_feb) begin
         y = date.year;
      end else if (date.year == '0) begin
         y = PREV_YEAR_ZERO;
      end else begin
         y = date.year - 7'd1;
      end
   end

   assign sum = {3'b000, date.day} + {2'b00, month_offset(date.month)}
              + {1'b0, y} + {3'b000, y[6:2]};
   assign weekday = mod7(sum);

endmodule

### design/rtc_calendar_with_weekday_top.sv
// Real-time clock and calendar with weekday.
// Request channel (req_*): a command and a free-running counter sample, plus
// time and date values used by the set command. Sample checks the upper 16
// bits of the counter against the next-second deadline and, when due, ticks
// the clock; start arms the deadline at sample plus cycles per second; set
// loads the time and date. Every request item yields one response item.
// Response channel (rsp_*): highest unit a sample tick changed (century wrap
// gives second), time and date after the item, and the weekday (0 Sunday).
// csr_write_data loads the cycles-per-second register when csr_write_enable
// is high; write it only while no item is in flight.
// Each item passes the input register, then the result register holding the
// cascade and weekday result.
// Throughput: one item per cycle while the response is not stalled; the whole
// calendar update sits between those two registers.
// A stalled response holds; the input register still takes one more item,
// then req_stall rises until the response is taken.
// Reset clears both stages, sets cycles per second to 1000000, deadline to
// zero and the date to 00:00:00, day 1, month 1, year 0.
`include "rtc_calendar_with_weekday_top_assert.svh"

module rtc_calendar_with_weekday_top
   import rtcwd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_counter_value,
   input  logic [6:0]  req_load_year,
   input  logic [3:0]  req_load_month,
   input  logic [4:0]  req_load_day,
   input  logic [4:0]  req_load_hour,
   input  logic [5:0]  req_load_minute,
   input  logic [5:0]  req_load_second,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_change_level,
   output logic [5:0]  rsp_now_second,
   output logic [5:0]  rsp_now_minute,
   output logic [4:0]  rsp_now_hour,
   output logic [4:0]  rsp_now_day,
   output logic [3:0]  rsp_now_month,
   output logic [6:0]  rsp_now_year,
   output logic [2:0]  rsp_weekday
);

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [1:0]      in_cmd_ff;
   logic [31:0]     in_counter_ff;
   rtcwd_date_type  in_load_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rtcwd_level_type out_level_ff;
   rtcwd_date_type  out_date_ff;
   logic [2:0]      out_weekday_ff;
   logic            out_ready;
   logic            step;
   logic            req_take;
   rtcwd_level_type level;
   rtcwd_date_type  date_next;
   rtcwd_date_type  req_load;
   logic [2:0]      weekday_next;

   assign out_ready    = ~out_valid_ff | ~rsp_stall;
   assign step         = in_valid_ff & out_ready;
   assign req_stall    = in_valid_ff & ~out_ready;
   assign req_take     = req_valid & ~req_stall;
   assign in_valid_in  = req_take | req_stall;
   assign out_valid_in = step | (out_valid_ff & rsp_stall);

   assign req_load = '{
      year: req_load_year, month: req_load_month, day: req_load_day,
      hour: req_load_hour, minute: req_load_minute, second: req_load_second
   };

   rtcwd_timekeeper u_timekeeper (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step_valid       (step),
      .cmd              (in_cmd_ff),
      .counter_value    (in_counter_ff),
      .load_date        (in_load_ff),
      .level            (level),
      .date_next        (date_next)
   );

   rtcwd_weekday u_weekday (
      .date    (date_next),
      .weekday (weekday_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff     <= req_cmd;
         in_counter_ff <= req_counter_value;
         in_load_ff    <= req_load;
      end
      if (step) begin
         out_level_ff   <= level;
         out_date_ff    <= date_next;
         out_weekday_ff <= weekday_next;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_change_level = out_level_ff;
   assign rsp_now_second   = out_date_ff.second;
   assign rsp_now_minute   = out_date_ff.minute;
   assign rsp_now_hour     = out_date_ff.hour;
   assign rsp_now_day      = out_date_ff.day;
   assign rsp_now_month    = out_date_ff.month;
   assign rsp_now_year     = out_date_ff.year;
   assign rsp_weekday      = out_weekday_ff;

   `RTCWD_CHECK_NOW(a_stall_on_full, in_valid_ff && out_valid_ff && rsp_stall, req_stall,
      "input stage not stalled while result is held")
   `RTCWD_CHECK_NEXT(a_cmd_no_tick, step && in_cmd_ff != CMD_SAMPLE,
      rsp_change_level == LEVEL_NONE, "non-sample item reported a change")
   `RTCWD_CHECK_NOW(a_carry_clears_second,
      rsp_valid && (rsp_change_level == LEVEL_MINUTE || rsp_change_level == LEVEL_HOUR ||
      rsp_change_level == LEVEL_DAY || rsp_change_level == LEVEL_MONTH ||
      rsp_change_level == LEVEL_YEAR), rsp_now_second == '0,
      "carry reported but second not zero")
   `RTCWD_CHECK_NOW(a_weekday_range, rsp_valid, rsp_weekday != 3'd7,
      "weekday out of range")

endmodule
